// ===== rtl/idset_pkg.sv =====
// shared constants and codes for the bounded identifier set table
// no dependencies; used by bounded_id_set_table
package idset_pkg;

   localparam int unsigned CapacityDefault = 64;
   localparam int unsigned IdWidth         = 32;
   localparam int unsigned OpWidth         = 2;
   localparam int unsigned StatusWidth     = 2;
   localparam int unsigned OccWidth        = 7;

   typedef enum logic [OpWidth-1:0] {
      OP_INSERT = 2'd0,
      OP_FIND   = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_ABSENT = 2'd2
   } status_type;

endpackage

// ===== rtl/idset_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies; instanced by bounded_id_set_table
module idset_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bounded_id_set_table.sv =====
// top level of the bounded identifier set table: sequencer, compare unit and count
// depends on idset_pkg and idset_ram
//
// Holds up to CAPACITY distinct 32-bit identifiers in a ram filled from entry 0 upward.
// A request is taken when req_valid is high and req_stall low; req_stall stays high while
// the request is worked on. Insert and find scan the stored entries through the ram's
// single read port, one entry per cycle through one 32-bit comparator, stopping at the
// first match: such a request holds the input until the scan ends, plus any wait for
// the output register, and its response is then registered. Flush, an insert into a
// full table and the unused operation code need no scan. A new request is accepted
// while an earlier response still waits on rsp_stall; the next response waits until
// the output register is free. No clearing pass is needed after reset.
module bounded_id_set_table #(
   parameter int unsigned CAPACITY = idset_pkg::CapacityDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [idset_pkg::OpWidth-1:0]       req_operation,
   input  logic [idset_pkg::IdWidth-1:0]       req_ident,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [idset_pkg::StatusWidth-1:0]   rsp_status,
   output logic [idset_pkg::OccWidth-1:0]      rsp_occupancy
);

   localparam int unsigned CntW  = $clog2(CAPACITY + 1);
   localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [CntW-1:0] CapCount = CntW'(CAPACITY);

   typedef enum logic {
      IDLE,
      WORK
   } state_type;

   state_type                            state_ff;
   logic [idset_pkg::OpWidth-1:0]        op_ff;
   logic [idset_pkg::IdWidth-1:0]        key_ff;
   logic [CntW-1:0]                      idx_ff;
   logic                                 pend_ff;
   logic [CntW-1:0]                      count_ff;
   logic                                 rsp_valid_ff;
   logic [idset_pkg::StatusWidth-1:0]    rsp_status_ff;
   logic [idset_pkg::OccWidth-1:0]       rsp_occ_ff;

   logic [CntW-1:0]                      count_in;
   idset_pkg::status_type                status_in;
   logic [idset_pkg::IdWidth-1:0]        rd_data;
   logic                                 issuing;
   logic                                 hit;
   logic                                 out_free;
   logic                                 done;
   logic                                 scan;
   logic                                 add_new;
   logic                                 finish;
   logic                                 rd_en;
   logic                                 wr_en;

   assign issuing  = idx_ff < count_ff;
   assign hit      = pend_ff && (rd_data == key_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      done      = 1'b0;
      scan      = 1'b0;
      add_new   = 1'b0;
      status_in = idset_pkg::ST_OK;
      count_in  = count_ff;
      if (state_ff == WORK) begin
         case (op_ff)
            idset_pkg::OP_INSERT: begin
               if (count_ff >= CapCount) begin
                  done      = 1'b1;
                  status_in = idset_pkg::ST_FULL;
               end else begin
                  scan = 1'b1;
                  if (hit) begin
                     done = 1'b1;
                  end else if (!issuing) begin
                     done     = 1'b1;
                     add_new  = 1'b1;
                     count_in = count_ff + CntW'(1);
                  end
               end
            end
            idset_pkg::OP_FIND: begin
               scan = 1'b1;
               if (hit) begin
                  done = 1'b1;
               end else if (!issuing) begin
                  done      = 1'b1;
                  status_in = idset_pkg::ST_ABSENT;
               end
            end
            idset_pkg::OP_FLUSH: begin
               done     = 1'b1;
               count_in = '0;
            end
            default: begin
               done = 1'b1;
            end
         endcase
      end
   end

   assign finish = done && out_free;
   assign rd_en  = scan && !done;
   assign wr_en  = finish && add_new;

   idset_ram #(
      .WIDTH (idset_pkg::IdWidth),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AddrW-1:0]),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AddrW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !finish) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_operation;
                  key_ff   <= req_ident;
                  idx_ff   <= '0;
                  pend_ff  <= 1'b0;
                  state_ff <= WORK;
               end
            end
            WORK: begin
               if (finish) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_in;
                  rsp_occ_ff    <= idset_pkg::OccWidth'(count_in);
                  count_ff      <= count_in;
                  state_ff      <= IDLE;
               end else if (rd_en) begin
                  idx_ff  <= idx_ff + CntW'(1);
                  pend_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign req_stall     = (state_ff != IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

   // count within capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CapCount)
      else $error("stored count above capacity");

   // appends only while room remains
   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < CapCount))
      else $error("store written while full");

   // full status only from a full table
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (finish && (status_in == idset_pkg::ST_FULL)) |-> (count_ff == CapCount))
      else $error("full status with room left");

   // flush empties the set and posts a response
   a_flush_empty: assert property (@(posedge clock) disable iff (reset)
      (finish && (op_ff == idset_pkg::OP_FLUSH)) |=> (count_ff == '0) && rsp_valid_ff)
      else $error("flush left entries");

endmodule
